/* src/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, register indexes and the CRC byte update for the serial
// frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Register indexes on the configuration port (byte address = 4 * index).
	localparam logic [2:0] REG_SYNC_VALUE  = 3'd0;
	localparam logic [2:0] REG_USE_INV_LEN = 3'd1;
	localparam logic [2:0] REG_CRC_POLY    = 3'd2;
	localparam logic [2:0] REG_CRC_INIT    = 3'd3;
	localparam logic [2:0] REG_CRC_XOR     = 3'd4;

	// Register reset values.
	localparam logic [7:0]  SYNC_RESET     = 8'hA5;
	localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
	localparam logic [15:0] CRC_INIT_RESET = 16'h0000;
	localparam logic [15:0] CRC_XOR_RESET  = 16'h0000;

	// Event codes reported with each result.
	typedef enum logic [2:0] {
		EV_TAKEN    = 3'd0,
		EV_SYNC     = 3'd1,
		EV_BADSYNC  = 3'd2,
		EV_HDR_OK   = 3'd3,
		EV_LEN_FAIL = 3'd4,
		EV_PAYLOAD  = 3'd5,
		EV_FRAME_OK = 3'd6,
		EV_CRC_ERR  = 3'd7
	} sfr_event_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [7:0]  sync_value;
		logic        use_inverted_length;
		logic [15:0] crc_polynomial;
		logic [15:0] crc_initial;
		logic [15:0] crc_final_xor;
	} sfr_cfg_t;

	// One byte of a non-reflected, MSB-first CRC-16 with implicit top bit.
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc,
		input logic [7:0] data, input logic [15:0] poly);
		logic [15:0] r;
		r = acc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ poly;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

/* src/sfr_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_regs
// Configuration register file behind an APB-style port. Writes complete in
// the access cycle; reads return the stored value, zero beyond the list.
// ----------------------------------------------------------------------------
module sfr_regs import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output sfr_cfg_t    cfg
);

	sfr_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value          <= SYNC_RESET;
			cfg_q.use_inverted_length <= 1'b1;
			cfg_q.crc_polynomial      <= CRC_POLY_RESET;
			cfg_q.crc_initial         <= CRC_INIT_RESET;
			cfg_q.crc_final_xor       <= CRC_XOR_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYNC_VALUE:  cfg_q.sync_value          <= pwdata[7:0];
				REG_USE_INV_LEN: cfg_q.use_inverted_length <= pwdata[0];
				REG_CRC_POLY:    cfg_q.crc_polynomial      <= pwdata[15:0];
				REG_CRC_INIT:    cfg_q.crc_initial         <= pwdata[15:0];
				REG_CRC_XOR:     cfg_q.crc_final_xor       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (reg_idx)
			REG_SYNC_VALUE:  prdata = {24'h0, cfg_q.sync_value};
			REG_USE_INV_LEN: prdata = {31'h0, cfg_q.use_inverted_length};
			REG_CRC_POLY:    prdata = {16'h0, cfg_q.crc_polynomial};
			REG_CRC_INIT:    prdata = {16'h0, cfg_q.crc_initial};
			REG_CRC_XOR:     prdata = {16'h0, cfg_q.crc_final_xor};
			default:         prdata = 32'h0;
		endcase
	end

endmodule

/* src/serial_frame_receiver.sv */
`timescale 1ns / 1ps
// A request moves from the input register to the result register; out_stall
// can hold it. Throughput: one byte per cycle unless out_stall holds; the frame
// state machine and byte-wide CRC update sit between these two registers.
// Reset: asynchronous, active low; the receiver starts idle, hunting for the
// sync byte; the control and state registers reset, the data registers do not.
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Byte-serial deframer: sync, big-endian length (with optional inverted
// copy), payload with running CRC-16, then CRC check.
// ----------------------------------------------------------------------------
module serial_frame_receiver import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [15:0] payload_index,
	output logic [15:0] frame_length,
	output logic        last_payload,
	output logic [15:0] computed_crc,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_CRC     = 2'd3
	} phase_t;

	sfr_cfg_t cfg;

	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline control.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic       advance;
	logic       accept_in;
	logic       step;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;
	assign step      = valid_s1 && advance;
	assign out_valid = out_valid_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept_in || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame state.
	phase_t      phase_q;
	logic [2:0]  hdr_cnt_q;
	logic [15:0] len_q;
	logic [15:0] inv_q;
	logic [15:0] left_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_hi_q;

	// Next state and result for the byte in the input register.
	phase_t      phase_d;
	logic [2:0]  hdr_cnt_d;
	logic [15:0] len_d;
	logic [15:0] inv_d;
	logic [15:0] left_d;
	logic [15:0] crc_d;
	logic [7:0]  crc_hi_d;
	sfr_event_t  ev_d;
	logic [15:0] idx_d;
	logic [15:0] flen_d;
	logic        last_d;
	logic [15:0] ccrc_d;
	logic [2:0]  hdr_need;
	logic [15:0] crc_final;

	assign hdr_need  = cfg.use_inverted_length ? 3'd4 : 3'd2;
	assign crc_final = crc_q ^ cfg.crc_final_xor;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		inv_d     = inv_q;
		left_d    = left_q;
		crc_d     = crc_q;
		crc_hi_d  = crc_hi_q;
		ev_d      = EV_TAKEN;
		idx_d     = 16'h0;
		flen_d    = 16'h0;
		last_d    = 1'b0;
		ccrc_d    = 16'h0;
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == cfg.sync_value) begin
					ev_d      = EV_SYNC;
					phase_d   = PH_HEADER;
					hdr_cnt_d = 3'd0;
					crc_d     = cfg.crc_initial;
				end else begin
					ev_d = EV_BADSYNC;
				end
			end
			PH_HEADER: begin
				// Collect length and inverted length, high byte first.
				unique case (hdr_cnt_q)
					3'd0:    len_d = {byte_s1, len_q[7:0]};
					3'd1:    len_d = {len_q[15:8], byte_s1};
					3'd2:    inv_d = {byte_s1, inv_q[7:0]};
					default: inv_d = {inv_q[15:8], byte_s1};
				endcase
				if ({1'b0, hdr_cnt_q} + 4'd1 >= {1'b0, hdr_need}) begin
					hdr_cnt_d = 3'd0;
					if (cfg.use_inverted_length && (len_d != ~inv_d)) begin
						ev_d    = EV_LEN_FAIL;
						phase_d = PH_IDLE;
					end else begin
						ev_d    = EV_HDR_OK;
						flen_d  = len_d;
						left_d  = len_d;
						phase_d = (len_d == 16'h0) ? PH_CRC : PH_PAYLOAD;
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				ev_d   = EV_PAYLOAD;
				flen_d = len_q;
				idx_d  = len_q - left_q;
				last_d = (left_q == 16'd1);
				crc_d  = crc16_byte(crc_q, byte_s1, cfg.crc_polynomial);
				left_d = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_d   = PH_CRC;
					hdr_cnt_d = 3'd0;
				end
			end
			PH_CRC: begin
				flen_d = len_q;
				if (hdr_cnt_q == 3'd0) begin
					ev_d      = EV_TAKEN;
					crc_hi_d  = byte_s1;
					hdr_cnt_d = 3'd1;
				end else begin
					ccrc_d    = crc_final;
					ev_d      = ({crc_hi_q, byte_s1} == crc_final) ? EV_FRAME_OK
						: EV_CRC_ERR;
					hdr_cnt_d = 3'd0;
					phase_d   = PH_IDLE;
				end
			end
			default: ;
		endcase
	end

	// State registers, updated once for each byte that moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hdr_cnt_q <= 3'd0;
			len_q     <= 16'h0;
			inv_q     <= 16'h0;
			left_q    <= 16'h0;
			crc_q     <= CRC_INIT_RESET;
			crc_hi_q  <= 8'h0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			inv_q     <= inv_d;
			left_q    <= left_d;
			crc_q     <= crc_d;
			crc_hi_q  <= crc_hi_d;
		end
	end

	// Result register.
	logic [2:0]  event_q;
	logic [7:0]  data_q;
	logic [15:0] idx_q;
	logic [15:0] flen_q;
	logic        last_q;
	logic [15:0] ccrc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= ev_d;
			data_q  <= byte_s1;
			idx_q   <= idx_d;
			flen_q  <= flen_d;
			last_q  <= last_d;
			ccrc_q  <= ccrc_d;
		end
	end

	assign event_res     = event_q;
	assign data_byte     = data_q;
	assign payload_index = idx_q;
	assign frame_length  = flen_q;
	assign last_payload  = last_q;
	assign computed_crc  = ccrc_q;

endmodule
